// ===== design/aecs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aecs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CODE_W      = 16;

    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_NOTICE = 2'd0,
        KIND_FATAL  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_ENTRY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_HEADER,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CODE_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_tbl_ctrl;

endpackage

`default_nettype wire

// ===== design/aecs_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aecs_table (
    input  wire logic                       i_clk,
    input  wire aecs_pkg::t_tbl_ctrl        i_ctrl,
    input  wire logic [aecs_pkg::CODE_W-1:0] i_code,
    output logic      [aecs_pkg::CODE_W-1:0] o_rdata,
    output logic                             o_match
);

    logic [aecs_pkg::CODE_W-1:0] r_mem [aecs_pkg::TABLE_DEPTH];
    logic [aecs_pkg::CODE_W-1:0] r_rdata;

    // raddr names the entry wanted in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= i_ctrl.wdata;
        end
        r_rdata <= r_mem[i_ctrl.raddr];
    end

    assign o_rdata = r_rdata;
    assign o_match = (r_rdata == i_code);

endmodule

`default_nettype wire

// ===== design/active_error_code_set_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Set and clear walk the list one entry per cycle through a single compare port;
// busy holds until the walk ends, and a set that adds a code strobes its result as busy drops.
// Report: the header state strobes the header, then the report state strobes one entry per cycle.
// One word at a time; busy drops as the last result strobes, ready for the next word.
// The receiver cannot stall; each result is held for exactly one cycle.
// Synchronous active-low reset empties the list and returns the sequencer to idle.
module active_error_code_set_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_error_code,
    output logic             o_result_valid,
    output logic [1:0]       o_result_kind,
    output logic [15:0]      o_reported_code,
    output logic [4:0]       o_active_count,
    output logic             o_any_error,
    output logic             o_last_of_run
);

    localparam int IDX_W = aecs_pkg::IDX_W;
    localparam int CNT_W = aecs_pkg::CNT_W;

    aecs_pkg::t_state          r_state, n_state;
    aecs_pkg::t_action         r_action, n_action;
    logic [15:0]               r_code, n_code;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [CNT_W-1:0]          r_count, n_count;

    logic                      r_ov, n_ov;
    aecs_pkg::t_kind           r_kind, n_kind;
    logic [15:0]               r_ocode, n_ocode;
    logic [CNT_W-1:0]          r_ocnt, n_ocnt;
    logic                      r_last, n_last;

    aecs_pkg::t_tbl_ctrl       w_ctrl;
    logic [15:0]               w_rdata;
    logic                      w_match;
    logic [CNT_W-1:0]          w_idx_inc;
    logic                      w_accept;

    aecs_table u_table (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_code  (r_code),
        .o_rdata (w_rdata),
        .o_match (w_match)
    );

    assign busy      = (r_state != aecs_pkg::ST_IDLE);
    assign w_accept  = start && !busy;
    assign w_idx_inc = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aecs_pkg::ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_code   <= n_code;
        r_idx    <= n_idx;
        r_kind   <= n_kind;
        r_ocode  <= n_ocode;
        r_ocnt   <= n_ocnt;
        r_last   <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_code       = r_code;
        n_idx        = r_idx;
        n_count      = r_count;
        n_ov         = 1'b0;
        n_kind       = r_kind;
        n_ocode      = r_ocode;
        n_ocnt       = r_ocnt;
        n_last       = r_last;
        w_ctrl.we    = 1'b0;
        w_ctrl.waddr = r_count[IDX_W-1:0];
        w_ctrl.wdata = r_code;

        unique case (r_state)
            aecs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_action = aecs_pkg::t_action'(i_action);
                    n_code   = i_error_code;
                    n_idx    = '0;
                    unique case (aecs_pkg::t_action'(i_action))
                        aecs_pkg::ACT_SET,
                        aecs_pkg::ACT_CLEAR:  n_state = aecs_pkg::ST_SEARCH;
                        aecs_pkg::ACT_REPORT: n_state = aecs_pkg::ST_HEADER;
                        default:              n_state = aecs_pkg::ST_IDLE;
                    endcase
                end
            end

            aecs_pkg::ST_SEARCH: begin
                if (r_idx == r_count) begin
                    // code absent: append on set, drop on clear
                    n_state = aecs_pkg::ST_IDLE;
                    if (r_action == aecs_pkg::ACT_SET) begin
                        w_ctrl.we = 1'b1;
                        n_ov      = 1'b1;
                        n_last    = 1'b1;
                        if (r_count == CNT_W'(aecs_pkg::TABLE_DEPTH - 1)) begin
                            n_count = '0;
                            n_kind  = aecs_pkg::KIND_FATAL;
                            n_ocode = '0;
                            n_ocnt  = '0;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_kind  = aecs_pkg::KIND_NOTICE;
                            n_ocode = r_code;
                            n_ocnt  = r_count + CNT_W'(1);
                        end
                    end
                end else if (w_match) begin
                    n_state = (r_action == aecs_pkg::ACT_CLEAR) ? aecs_pkg::ST_SHIFT
                                                                : aecs_pkg::ST_IDLE;
                end else begin
                    n_idx = w_idx_inc;
                end
            end

            aecs_pkg::ST_SHIFT: begin
                // move the next entry down over the removed one
                if (w_idx_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = aecs_pkg::ST_IDLE;
                end else begin
                    w_ctrl.we    = 1'b1;
                    w_ctrl.waddr = r_idx[IDX_W-1:0];
                    w_ctrl.wdata = w_rdata;
                    n_idx        = w_idx_inc;
                end
            end

            aecs_pkg::ST_HEADER: begin
                n_ov    = 1'b1;
                n_kind  = aecs_pkg::KIND_HEADER;
                n_ocode = '0;
                n_ocnt  = r_count;
                n_last  = (r_count == '0);
                n_idx   = '0;
                n_state = (r_count == '0) ? aecs_pkg::ST_IDLE : aecs_pkg::ST_REPORT;
            end

            aecs_pkg::ST_REPORT: begin
                n_ov    = 1'b1;
                n_kind  = aecs_pkg::KIND_ENTRY;
                n_ocode = w_rdata;
                n_ocnt  = r_count;
                n_last  = (w_idx_inc == r_count);
                n_idx   = w_idx_inc;
                if (w_idx_inc == r_count) begin
                    n_state = aecs_pkg::ST_IDLE;
                end
            end

            default: n_state = aecs_pkg::ST_IDLE;
        endcase

        // fetch the entry that the next state compares, moves down or reports
        w_ctrl.raddr = (n_state == aecs_pkg::ST_SHIFT) ? n_idx[IDX_W-1:0] + IDX_W'(1)
                                                       : n_idx[IDX_W-1:0];
    end

    assign o_result_valid  = r_ov;
    assign o_result_kind   = r_kind;
    assign o_reported_code = r_ocode;
    assign o_active_count  = 5'(r_ocnt);
    assign o_any_error     = (r_ocnt != '0);
    assign o_last_of_run   = r_last;

    a_count_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(aecs_pkg::TABLE_DEPTH))
        else $error("active count reached table depth");

    a_fatal_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == aecs_pkg::KIND_FATAL) |->
        (o_active_count == 5'd0 && !o_any_error && o_last_of_run))
        else $error("fatal result does not report an empty list");

    a_report_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == aecs_pkg::ACT_REPORT) |->
        ##2 (o_result_valid && o_result_kind == aecs_pkg::KIND_HEADER))
        else $error("report header missing two cycles after start");

    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == aecs_pkg::KIND_ENTRY) |-> o_any_error)
        else $error("report entry emitted from an empty list");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_run) |-> !busy)
        else $error("sequencer still busy after last result");

endmodule

`default_nettype wire

// ===== verif/tb_active_error_code_set_top.sv =====
`timescale 1ns / 1ps

module tb_active_error_code_set_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 2 * aecs_pkg::TABLE_DEPTH + 8;
    localparam int MAX_PRINTED    = 40;

    typedef struct {
        aecs_pkg::t_kind kind;
        logic [15:0]     code;
        logic [4:0]      count;
        logic            any_err;
        logic            last;
    } t_result_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    aecs_pkg::t_action i_action;
    logic [15:0]       i_error_code;
    logic              o_result_valid;
    logic [1:0]        o_result_kind;
    logic [15:0]       o_reported_code;
    logic [4:0]        o_active_count;
    logic              o_any_error;
    logic              o_last_of_run;

    // Shadow copy of the active-code list
    logic [15:0]  list_codes [aecs_pkg::TABLE_DEPTH];
    int           list_len;
    t_result_word pending_results [$];
    t_result_word want;

    int error_count;
    int items_sent;
    int results_checked;
    int fatal_events;
    int report_words;
    int idle_pct;
    int idle_cycles;

    active_error_code_set_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_error_code    (i_error_code),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_reported_code (o_reported_code),
        .o_active_count  (o_active_count),
        .o_any_error     (o_any_error),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_error(input string field, input int got, input int exp_val);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t mismatch %s: got %0h, wanted %0h", $realtime, field, got, exp_val);
    endtask

    function automatic void queue_result(input aecs_pkg::t_kind kind, input logic [15:0] code,
                                         input int count, input logic last);
        t_result_word r;
        r.kind    = kind;
        r.code    = code;
        r.count   = count[4:0];
        r.any_err = (count != 0);
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // Update the shadow list for one accepted word and queue what it emits
    function automatic void predict_word(input aecs_pkg::t_action act, input logic [15:0] code);
        int pos;
        int k;
        pos = list_len;
        for (k = 0; k < list_len; k++)
            if (pos == list_len && list_codes[k] == code)
                pos = k;
        case (act)
            aecs_pkg::ACT_SET: begin
                if (pos == list_len) begin
                    list_codes[list_len] = code;
                    list_len++;
                    if (list_len >= aecs_pkg::TABLE_DEPTH) begin
                        list_len = 0;
                        fatal_events++;
                        queue_result(aecs_pkg::KIND_FATAL, 16'h0000, 0, 1'b1);
                    end else begin
                        queue_result(aecs_pkg::KIND_NOTICE, code, list_len, 1'b1);
                    end
                end
            end
            aecs_pkg::ACT_CLEAR: begin
                if (pos < list_len) begin
                    for (k = pos; k < list_len - 1; k++)
                        list_codes[k] = list_codes[k + 1];
                    list_len--;
                end
            end
            aecs_pkg::ACT_REPORT: begin
                report_words++;
                queue_result(aecs_pkg::KIND_HEADER, 16'h0000, list_len, list_len == 0);
                for (k = 0; k < list_len; k++)
                    queue_result(aecs_pkg::KIND_ENTRY, list_codes[k], list_len,
                                 k + 1 == list_len);
            end
            default: ;
        endcase
    endfunction

    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold the word until busy is low at an edge; start stays high unless a gap follows
    task automatic send_word(input aecs_pkg::t_action act, input logic [15:0] code);
        start        <= 1'b1;
        i_action     <= act;
        i_error_code <= code;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_word(act, code);
        if (act != aecs_pkg::ACT_NONE)
            items_sent++;
        idle_gap();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] choose_code(input aecs_pkg::t_action act);
        int r;
        r = $urandom_range(99);
        if (act != aecs_pkg::ACT_REPORT && list_len > 0 &&
            r < (act == aecs_pkg::ACT_CLEAR ? 65 : 15))
            return list_codes[$urandom_range(list_len - 1)];
        if (r < 70)
            return 16'h0100 + 16'($urandom_range(31));
        return 16'($urandom);
    endfunction

    task automatic test_directed_basics();
        send_word(aecs_pkg::ACT_REPORT, 16'hFFFF);
        send_word(aecs_pkg::ACT_SET,    16'h0000);
        send_word(aecs_pkg::ACT_SET,    16'hFFFF);
        send_word(aecs_pkg::ACT_SET,    16'hFFFF);
        send_word(aecs_pkg::ACT_CLEAR,  16'h1234);
        send_word(aecs_pkg::ACT_NONE,   16'hAAAA);
        send_word(aecs_pkg::ACT_REPORT, 16'h0000);
        send_word(aecs_pkg::ACT_CLEAR,  16'h0000);
    endtask

    // Fill the list from one entry until it overflows, then report the empty list
    task automatic test_list_full();
        int k;
        for (k = 0; k < aecs_pkg::TABLE_DEPTH - 1; k++) begin
            if (k == 0)
                send_word(aecs_pkg::ACT_SET, 16'h5555);
            else if (k == 1)
                send_word(aecs_pkg::ACT_SET, 16'hAAAA);
            else
                send_word(aecs_pkg::ACT_SET, 16'h1000 + 16'(k));
        end
        send_word(aecs_pkg::ACT_REPORT, 16'h0000);
    endtask

    task automatic test_random_traffic(input int pct, input int n_words);
        int                sent;
        int                r;
        aecs_pkg::t_action act;
        idle_pct = pct;
        sent     = 0;
        while (sent < n_words) begin
            r = $urandom_range(99);
            if (r < 45)
                act = aecs_pkg::ACT_SET;
            else if (r < 75)
                act = aecs_pkg::ACT_CLEAR;
            else if (r < 92)
                act = aecs_pkg::ACT_REPORT;
            else
                act = aecs_pkg::ACT_NONE;
            send_word(act, choose_code(act));
            if (act != aecs_pkg::ACT_NONE)
                sent++;
            if (sent == n_words / 2 && act != aecs_pkg::ACT_NONE)
                drain_results();
        end
    endtask

    // Compare each strobed result with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                note_error("unexpected result kind", o_result_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind != want.kind)
                    note_error("result_kind", o_result_kind, want.kind);
                if (o_reported_code != want.code)
                    note_error("reported_code", o_reported_code, want.code);
                if (o_active_count != want.count)
                    note_error("active_count", o_active_count, want.count);
                if (o_any_error != want.any_err)
                    note_error("any_error", o_any_error, want.any_err);
                if (o_last_of_run != want.last)
                    note_error("last_of_run", o_last_of_run, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        fatal_events    = 0;
        report_words    = 0;
        idle_cycles     = 0;
        list_len        = 0;
        idle_pct        = 35;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= aecs_pkg::ACT_NONE;
        i_error_code <= 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_list_full();
        test_random_traffic(35, 66);
        test_random_traffic(62, 66);
        test_random_traffic(0, 66);
        drain_results();

        $display("covered %0d words: %0d reports, %0d list-full overflows",
                 items_sent, report_words, fatal_events);
        $display("checked %0d results under three sender idle rates", results_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
